### rtl/eid_pkg.sv
// shared types and constants for the extremum interval detector
// no dependencies; used by every module of the block by scoped names

package eid_pkg;

  // field widths
  localparam int SampleW   = 32;
  localparam int ThreshW   = 16;
  localparam int StepW     = 32;
  localparam int TickW     = 32;
  localparam int IntervalW = 48;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 32;

  // register reset values
  localparam logic [ThreshW-1:0] RelThresholdRst = 16'd7;
  localparam logic [StepW-1:0]   TimeStepRst     = 32'd65536;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_REL_THRESHOLD = 1'b0,
    REG_TIME_STEP     = 1'b1
  } cfg_reg_t;

  // window fill levels
  typedef enum logic [1:0] {
    FILL_EMPTY = 2'd0,
    FILL_ONE   = 2'd1,
    FILL_FULL  = 2'd2
  } fill_t;

  // accepted extremum handed from the window stage to the scaling stage
  typedef struct packed {
    logic             valid;
    logic [TickW-1:0] ticks;
    logic             is_max;
  } emit_t;

endpackage

### rtl/eid_window.sv
// input register, three-sample window and extremum decision
// depends on eid_pkg (widths, fill_t, emit_t)

module eid_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [eid_pkg::SampleW-1:0]   in_sample,
  input  logic                          in_last,
  input  logic [eid_pkg::ThreshW-1:0]   rel_threshold,
  output eid_pkg::emit_t                emit
);

  localparam int ProdW = eid_pkg::SampleW + eid_pkg::ThreshW;

  // input register
  logic                        s1_valid_r;
  logic [eid_pkg::SampleW-1:0] s1_sample_r;
  logic                        s1_last_r;

  // window state
  logic [eid_pkg::SampleW-1:0] prev_r, prev_nxt;
  logic [eid_pkg::SampleW-1:0] mid_r, mid_nxt;
  logic [eid_pkg::SampleW-1:0] ext_val_r, ext_val_nxt;
  logic [eid_pkg::TickW-1:0]   ext_tick_r, ext_tick_nxt;
  logic [eid_pkg::TickW-1:0]   tick_r, tick_nxt;
  eid_pkg::fill_t              fill_r, fill_nxt;
  logic                        found_r, found_nxt;
  eid_pkg::emit_t              emit_r, emit_nxt;

  // decision terms
  logic [eid_pkg::TickW-1:0]   mid_tick;
  logic                        is_max, is_min;
  logic [eid_pkg::SampleW-1:0] diff;
  logic [ProdW-1:0]            diff_sh;
  logic [ProdW-1:0]            thr_prod;
  logic                        far;
  logic                        take;

  assign mid_tick = tick_r - eid_pkg::TickW'(1);
  assign is_max   = (mid_r > prev_r) && (mid_r > s1_sample_r);
  assign is_min   = (mid_r < prev_r) && (mid_r < s1_sample_r);
  assign diff     = (ext_val_r > mid_r) ? (ext_val_r - mid_r) : (mid_r - ext_val_r);
  assign diff_sh  = {diff, {eid_pkg::ThreshW{1'b0}}};
  assign thr_prod = ProdW'(rel_threshold) * ProdW'(ext_val_r);
  assign far      = diff_sh > thr_prod;
  assign take     = (is_max || is_min) && far;

  // next state for one processed sample
  always_comb begin
    prev_nxt     = prev_r;
    mid_nxt      = mid_r;
    ext_val_nxt  = ext_val_r;
    ext_tick_nxt = ext_tick_r;
    tick_nxt     = tick_r;
    fill_nxt     = fill_r;
    found_nxt    = found_r;
    emit_nxt     = '0;
    emit_nxt.ticks  = mid_tick - ext_tick_r;
    emit_nxt.is_max = is_max;
    if (s1_valid_r) begin
      tick_nxt = tick_r + eid_pkg::TickW'(1);
      case (fill_r)
        eid_pkg::FILL_EMPTY: begin
          prev_nxt    = s1_sample_r;
          ext_val_nxt = s1_sample_r;
          fill_nxt    = eid_pkg::FILL_ONE;
        end
        eid_pkg::FILL_ONE: begin
          mid_nxt  = s1_sample_r;
          fill_nxt = eid_pkg::FILL_FULL;
        end
        default: begin
          if (take) begin
            emit_nxt.valid = found_r || is_max;
            ext_tick_nxt   = mid_tick;
            ext_val_nxt    = mid_r;
            found_nxt      = 1'b1;
          end
          // before the first extremum prev always shifts, after it holds on plateaus
          if (!found_r || (mid_r != s1_sample_r)) prev_nxt = mid_r;
          mid_nxt = s1_sample_r;
        end
      endcase
      // final sample of a run clears the window
      if (s1_last_r) begin
        prev_nxt     = '0;
        mid_nxt      = '0;
        ext_val_nxt  = '0;
        ext_tick_nxt = '0;
        tick_nxt     = '0;
        fill_nxt     = eid_pkg::FILL_EMPTY;
        found_nxt    = 1'b0;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_r     <= '0;
      mid_r      <= '0;
      ext_val_r  <= '0;
      ext_tick_r <= '0;
      tick_r     <= '0;
      fill_r     <= eid_pkg::FILL_EMPTY;
      found_r    <= 1'b0;
      emit_r     <= '0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      prev_r     <= prev_nxt;
      mid_r      <= mid_nxt;
      ext_val_r  <= ext_val_nxt;
      ext_tick_r <= ext_tick_nxt;
      tick_r     <= tick_nxt;
      fill_r     <= fill_nxt;
      found_r    <= found_nxt;
      emit_r     <= emit_nxt;
    end
  end

  assign emit = emit_r;

endmodule

### rtl/eid_scale.sv
// scales tick distance by the sample period and saturates into the output register
// depends on eid_pkg (widths, emit_t)

module eid_scale (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  eid_pkg::emit_t                  emit,
  input  logic [eid_pkg::StepW-1:0]       time_step,
  output logic                            out_valid,
  output logic [eid_pkg::IntervalW-1:0]   out_interval,
  output logic                            out_is_max
);

  localparam int FullW = eid_pkg::TickW + eid_pkg::StepW;

  logic [FullW-1:0]              prod;
  logic [eid_pkg::IntervalW-1:0] sat;
  logic                          out_valid_r;
  logic [eid_pkg::IntervalW-1:0] out_interval_r;
  logic                          out_is_max_r;

  // tick distance times period, clamped to the interval width
  assign prod = FullW'(emit.ticks) * FullW'(time_step);
  assign sat  = (prod[FullW-1:eid_pkg::IntervalW] != '0) ? '1
                                                         : prod[eid_pkg::IntervalW-1:0];

  // output word payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_interval_r <= sat;
      out_is_max_r   <= emit.is_max;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit.valid;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_interval = out_interval_r;
  assign out_is_max   = out_is_max_r;

endmodule

### rtl/extremum_interval_detector.sv
// extremum interval detector top level: config registers and stage wiring
// depends on eid_pkg, eid_window, eid_scale
// an accepted input word goes through the window emit register, then the output register
// throughput: one word per cycle; every stage advances unless an output word is stalled
// in_stall follows out_stall while an output word is waiting
// reset (rst_n low, synchronous) clears the window and restores both config registers

module extremum_interval_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [eid_pkg::SampleW-1:0]      in_sample,
  input  logic                             in_last_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [eid_pkg::IntervalW-1:0]    out_interval,
  output logic                             out_is_max,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [eid_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [eid_pkg::CfgDataW-1:0]     cfg_data
);

  logic [eid_pkg::ThreshW-1:0] rel_threshold_r;
  logic [eid_pkg::StepW-1:0]   time_step_r;
  logic                        adv;
  eid_pkg::emit_t              emit;

  // whole pipeline moves unless a finished word is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_threshold_r <= eid_pkg::RelThresholdRst;
      time_step_r     <= eid_pkg::TimeStepRst;
    end else if (cfg_valid && cfg_ready) begin
      case (eid_pkg::cfg_reg_t'(cfg_index))
        eid_pkg::REG_REL_THRESHOLD: rel_threshold_r <= cfg_data[eid_pkg::ThreshW-1:0];
        eid_pkg::REG_TIME_STEP:     time_step_r     <= cfg_data[eid_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // window and extremum decision
  eid_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_sample     (in_sample),
    .in_last       (in_last_sample),
    .rel_threshold (rel_threshold_r),
    .emit          (emit)
  );

  // interval scaling and output register
  eid_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .emit         (emit),
    .time_step    (time_step_r),
    .out_valid    (out_valid),
    .out_interval (out_interval),
    .out_is_max   (out_is_max)
  );

endmodule

### test/tb_extremum_interval_detector.sv
// testbench for extremum_interval_detector: directed and random sample streams
// checked word by word against an in-bench window predictor
// depends on eid_pkg and the extremum_interval_detector rtl

module tb_extremum_interval_detector;
  import eid_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } sample_word_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval;
    logic                 is_max;
  } interval_word_t;

  localparam logic [IntervalW-1:0] IntervalSat = '1;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;
  localparam int PhaseWords  = 100;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [SampleW-1:0]   in_sample      = '0;
  logic                 in_last_sample = 1'b0;
  logic                 out_valid;
  logic                 out_stall      = 1'b1;
  logic [IntervalW-1:0] out_interval;
  logic                 out_is_max;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index      = '0;
  logic [CfgDataW-1:0]  cfg_data       = '0;

  sample_word_t   samples_pending[$];
  interval_word_t intervals_due[$];
  int unsigned    mismatches  = 0;
  int unsigned    in_gap_max  = 9;
  int unsigned    out_gap_max = 9;
  int unsigned    in_gap      = 0;
  int unsigned    out_wait    = 0;
  int unsigned    hold_left   = 0;
  logic           hold_go     = 1'b0;

  // predictor copy of the registers and the sample window
  logic [ThreshW-1:0] thr_q      = RelThresholdRst;
  logic [StepW-1:0]   step_q     = TimeStepRst;
  logic [SampleW-1:0] prev_q     = '0;
  logic [SampleW-1:0] mid_q      = '0;
  logic [SampleW-1:0] ext_val_q  = '0;
  logic [TickW-1:0]   ext_tick_q = '0;
  logic [TickW-1:0]   tick_q     = '0;
  fill_t              fill_q     = FILL_EMPTY;
  logic               found_q    = 1'b0;

  extremum_interval_detector u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_interval   (out_interval),
    .out_is_max     (out_is_max),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // relative change test against the last accepted extremum, exact in 64 bits
  function automatic logic far_from_extremum(input logic [SampleW-1:0] m);
    logic [63:0] diff;
    logic [63:0] bound;
    diff  = (ext_val_q > m) ? ({32'd0, ext_val_q} - {32'd0, m})
                            : ({32'd0, m} - {32'd0, ext_val_q});
    bound = {48'd0, thr_q} * {32'd0, ext_val_q};
    return (diff << 16) > bound;
  endfunction

  // advance the window by one sample and queue the interval it reports, if any
  function automatic void predict_extremum(input sample_word_t w);
    logic [TickW-1:0] mid_tick;
    logic [63:0]      span;
    logic             peak;
    logic             dip;
    logic             was_found;
    interval_word_t   r;
    if (fill_q == FILL_EMPTY) begin
      prev_q    = w.sample;
      ext_val_q = w.sample;
      fill_q    = FILL_ONE;
    end else if (fill_q == FILL_ONE) begin
      mid_q  = w.sample;
      fill_q = FILL_FULL;
    end else begin
      mid_tick  = tick_q - 1;
      peak      = (mid_q > prev_q) && (mid_q > w.sample);
      dip       = (mid_q < prev_q) && (mid_q < w.sample);
      was_found = found_q;
      if ((peak || dip) && far_from_extremum(mid_q)) begin
        // a minimum ahead of the first extremum is recorded silently
        if (was_found || peak) begin
          span = {32'd0, mid_tick - ext_tick_q} * {32'd0, step_q};
          r.interval = (span > {16'd0, IntervalSat}) ? IntervalSat : span[IntervalW-1:0];
          r.is_max   = peak;
          intervals_due.push_back(r);
        end
        ext_tick_q = mid_tick;
        ext_val_q  = mid_q;
        found_q    = 1'b1;
      end
      // once an extremum is known the previous neighbor holds across plateaus
      if (!was_found || mid_q != w.sample) prev_q = mid_q;
      mid_q = w.sample;
    end
    tick_q = tick_q + 1;
    if (w.last) begin
      prev_q     = '0;
      mid_q      = '0;
      ext_val_q  = '0;
      ext_tick_q = '0;
      tick_q     = '0;
      fill_q     = FILL_EMPTY;
      found_q    = 1'b0;
    end
  endfunction

  // sample driver: predicts on acceptance, then offers the next word after its gap
  always @(posedge clk) begin
    sample_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        w.sample = in_sample;
        w.last   = in_last_sample;
        predict_extremum(w);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (samples_pending.size() != 0) begin
          w = samples_pending.pop_front();
          in_valid       <= 1'b1;
          in_sample      <= w.sample;
          in_last_sample <= w.last;
          in_gap         <= $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted word with the oldest expected interval
  always @(posedge clk) begin
    interval_word_t want;
    int unsigned    nxt;
    if (!rst_n) begin
      out_stall <= 1'b1;
      out_wait  <= 0;
    end else begin
      nxt = out_wait;
      if (out_valid && !out_stall) begin
        if (intervals_due.size() == 0) begin
          $error("unexpected word: interval %0d is_max %0d", out_interval, out_is_max);
          mismatches++;
        end else begin
          want = intervals_due.pop_front();
          if (out_interval !== want.interval) begin
            $error("interval: expected %0d, got %0d", want.interval, out_interval);
            mismatches++;
          end
          if (out_is_max !== want.is_max) begin
            $error("is_max: expected %0d, got %0d", want.is_max, out_is_max);
            mismatches++;
          end
        end
        nxt = $urandom_range(0, out_gap_max);
      end else if (out_valid && nxt != 0) begin
        nxt = nxt - 1;
      end
      out_wait  <= nxt;
      out_stall <= (nxt != 0) || (hold_left != 0);
    end
  end

  // long receiver hold-off, counted here so the block backs up into its input
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic push_word(input logic [SampleW-1:0] s, input logic last);
    sample_word_t w;
    w.sample = s;
    w.last   = last;
    samples_pending.push_back(w);
  endtask

  // random walk with direction flips and plateaus, clamped at both ends
  task automatic push_walk(input int unsigned len, input bit close);
    logic [SampleW-1:0] cur;
    logic [SampleW-1:0] amp;
    logic [SampleW-1:0] d;
    bit                 up;
    int unsigned        r;
    int unsigned        i;
    cur = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
    amp = 32'd1 << $urandom_range(0, 31);
    up  = 1'($urandom_range(0, 1));
    for (i = 0; i < len; i++) begin
      push_word(cur, close && (i == len - 1));
      r = $urandom_range(0, 7);
      if (r < 2) up = !up;
      if (r != 2) begin
        d = ($urandom % amp) + 1;
        if (up) cur = (cur > 32'hFFFF_FFFF - d) ? 32'hFFFF_FFFF : cur + d;
        else    cur = (cur < d) ? 32'd0 : cur - d;
      end
    end
  endtask

  task automatic push_noise(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      push_word($urandom, $urandom_range(0, 15) == 0);
    end
  endtask

  // mostly well-formed runs, some cut short, some unstructured noise
  task automatic run_mix(input int unsigned count);
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    @(negedge clk);
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(3, 40);
        push_walk(len, $urandom_range(0, 3) != 0);
      end else if (kind == 7) begin
        len = $urandom_range(1, 2);
        push_walk(len, 1'b1);
      end else begin
        len = $urandom_range(1, 8);
        push_noise(len);
      end
      n += len;
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_REL_THRESHOLD) thr_q = val[ThreshW-1:0];
    else                          step_q = val;
  endtask

  // all words accepted and answered, then let words without a result drain
  task automatic wait_idle();
    @(negedge clk);
    while (samples_pending.size() != 0 || in_valid || intervals_due.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    int unsigned        p;
    logic [ThreshW-1:0] thr;
    logic [StepW-1:0]   stp;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero first sample, then maximum, minimum, plateau and maximum
    push_word(32'd0, 1'b0);
    push_word(32'd5, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(32'd1, 1'b0);
    // full-scale swings, closed on a result-bearing final sample
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    // leading minimum stays silent, the following maximum reports
    push_word(32'd10, 1'b0);
    push_word(32'd4, 1'b0);
    push_word(32'd10, 1'b0);
    push_word(32'd20, 1'b0);
    push_word(32'd5, 1'b1);
    // change exactly at the threshold is rejected
    push_word(32'd65536, 1'b0);
    push_word(32'd65543, 1'b0);
    push_word(32'd0, 1'b1);
    // one step above the threshold is accepted
    push_word(32'd65536, 1'b0);
    push_word(32'd65544, 1'b0);
    push_word(32'd0, 1'b1);
    wait_idle();

    // random phases over several register settings and idle patterns
    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin thr = '0;        stp = 32'd1;   in_gap_max = 9; out_gap_max = 9; end
        1: begin thr = '1;        stp = '1;      in_gap_max = 0; out_gap_max = 9; end
        2: begin thr = RelThresholdRst; stp = TimeStepRst; in_gap_max = 9; out_gap_max = 0; end
        3: begin
          thr = ThreshW'($urandom_range(0, 65535));
          stp = $urandom;
          in_gap_max  = 0;
          out_gap_max = 9;
        end
        4: begin thr = 16'd1000;  stp = 32'd0;   in_gap_max = 9; out_gap_max = 9; end
        5: begin
          thr = ThreshW'($urandom_range(0, 65535));
          stp = $urandom;
          in_gap_max  = 9;
          out_gap_max = 9;
        end
        default: begin thr = 16'd300; stp = 32'd3; in_gap_max = 0; out_gap_max = 0; end
      endcase
      write_reg(REG_REL_THRESHOLD, {16'd0, thr});
      write_reg(REG_TIME_STEP, stp);
      run_mix(PhaseWords);
      if (p == 3) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[extremum_interval_detector] OK");
    end else begin
      $display("[extremum_interval_detector] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[extremum_interval_detector] ERROR");
    $finish;
  end

endmodule

### files.f
rtl/eid_pkg.sv
rtl/eid_window.sv
rtl/eid_scale.sv
rtl/extremum_interval_detector.sv
test/tb_extremum_interval_detector.sv
